@@ hw/rtl/tce_pkg.sv @@
// Shared types and constants for the timer capture entropy extractor.
// No dependencies; imported by every module of the block.
package tce_pkg;

    localparam int CAP_W  = 16;
    localparam int WORD_W = 32;
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    localparam int DEF_SYNC_PERIOD_WORDS = 256;
    localparam int DEF_SYNC_WORDS        = 4;

    localparam logic [WORD_W-1:0] SYNC_PATTERN = 32'hF0F0_F0F0;

    // register word index (paddr[2])
    localparam logic REG_MODE = 1'b0;

    // mode codes
    localparam logic MODE_VN    = 1'b0;
    localparam logic MODE_DELTA = 1'b1;

    // one request handed from the core to the emitter
    typedef struct packed {
        logic              valid;
        logic              has_sync;
        logic [WORD_W-1:0] word;
    } tce_desc_t;

endpackage

@@ hw/rtl/tce_core.sv @@
// Input register and per-capture state update (entropy and delta paths).
// Depends on tce_pkg; feeds result descriptors to tce_emit.
module tce_core
    import tce_pkg::*;
#(
    parameter int SYNC_PERIOD_WORDS = DEF_SYNC_PERIOD_WORDS
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             capture_valid,
    output logic             capture_stall,
    input  logic [CAP_W-1:0] capture_value,
    input  logic             mode,
    input  logic             phase_clear,
    input  logic             desc_ready,
    output tce_desc_t        desc
);

    localparam int WUS_W = $clog2(SYNC_PERIOD_WORDS + 1);

    logic [CAP_W-1:0]  cap_reg;
    logic              cap_valid_reg, cap_valid_next;
    logic [1:0]        phase_reg, phase_next;
    logic              held_reg, held_next;
    logic              fpb_reg, fpb_next;
    logic [WORD_W-1:0] acc_reg, acc_next;
    logic [4:0]        bits_reg, bits_next;
    logic [CAP_W-1:0]  high_reg, high_next;
    logic [WUS_W-1:0]  wus_reg, wus_next;

    logic      lsb;
    logic      b_bit;
    logic      produces;
    logic      advance;
    logic      accept;
    tce_desc_t res;

    assign lsb   = cap_reg[0];
    assign b_bit = held_reg ^ lsb;

    // next state and result for the capture in the input register
    always_comb
    begin
        phase_next   = phase_reg;
        held_next    = held_reg;
        fpb_next     = fpb_reg;
        acc_next     = acc_reg;
        bits_next    = bits_reg;
        high_next    = high_reg;
        wus_next     = wus_reg;
        res.valid    = 1'b0;
        res.has_sync = 1'b0;
        res.word     = acc_reg;
        if (mode == MODE_VN)
        begin
            case (phase_reg)
                2'd0:
                begin
                    held_next  = lsb;
                    phase_next = 2'd1;
                end
                2'd1:
                begin
                    fpb_next   = held_reg ^ lsb;
                    phase_next = 2'd2;
                end
                2'd2:
                begin
                    held_next  = lsb;
                    phase_next = 2'd3;
                end
                default:
                begin
                    phase_next = 2'd0;
                    if (fpb_reg != b_bit)
                    begin
                        acc_next  = {acc_reg[WORD_W-2:0], fpb_reg};
                        bits_next = bits_reg + 5'd1;
                        res.word  = acc_next;
                        res.valid = (bits_reg == 5'd31);
                    end
                end
            endcase
        end
        else if (!phase_reg[0])
        begin
            high_next  = cap_reg;
            phase_next = 2'd1;
        end
        else
        begin
            phase_next = 2'd0;
            res.valid  = 1'b1;
            res.word   = {high_reg, cap_reg};
            if (wus_reg == '0)
            begin
                res.has_sync = 1'b1;
                wus_next     = WUS_W'(SYNC_PERIOD_WORDS - 1);
            end
            else
            begin
                wus_next = wus_reg - 1'b1;
            end
        end
    end

    // items with no result move on even while the emitter is busy
    assign produces      = res.valid;
    assign advance       = cap_valid_reg && (!produces || desc_ready);
    assign capture_stall = cap_valid_reg && !advance;
    assign accept        = capture_valid && !capture_stall;

    assign desc.valid    = advance && produces;
    assign desc.has_sync = res.has_sync;
    assign desc.word     = res.word;

    always_comb
    begin
        cap_valid_next = cap_valid_reg;
        if (accept)
            cap_valid_next = 1'b1;
        else if (advance)
            cap_valid_next = 1'b0;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_valid_reg <= 1'b0;
            phase_reg     <= '0;
            held_reg      <= 1'b0;
            fpb_reg       <= 1'b0;
            acc_reg       <= '0;
            bits_reg      <= '0;
            high_reg      <= '0;
            wus_reg       <= '0;
        end
        else
        begin
            cap_valid_reg <= cap_valid_next;
            if (phase_clear)
            begin
                phase_reg <= '0;
            end
            else if (advance)
            begin
                phase_reg <= phase_next;
                held_reg  <= held_next;
                fpb_reg   <= fpb_next;
                acc_reg   <= acc_next;
                bits_reg  <= bits_next;
                high_reg  <= high_next;
                wus_reg   <= wus_next;
            end
        end
    end

    // capture payload
    always_ff @(posedge clk)
    begin
        if (accept)
            cap_reg <= capture_value;
    end

    // a held capture that cannot move on stays held
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (cap_valid_reg && !advance) |=> cap_valid_reg)
        else $error("held capture dropped");

    // a result request goes out only when the emitter can take it
    a_desc_ready: assert property (@(posedge clk) disable iff (!rst_n)
        desc.valid |-> desc_ready)
        else $error("descriptor issued to busy emitter");

    // sync burst only requested in delta mode
    a_sync_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (desc.valid && desc.has_sync) |-> (mode == MODE_DELTA))
        else $error("sync requested in entropy mode");

endmodule

@@ hw/rtl/tce_emit.sv @@
// Result register: plays out the sync burst and then the data word.
// Depends on tce_pkg; takes descriptors from tce_core.
module tce_emit
    import tce_pkg::*;
#(
    parameter int SYNC_WORDS = DEF_SYNC_WORDS
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  tce_desc_t         desc,
    output logic              desc_ready,
    output logic              result_valid,
    input  logic              result_stall,
    output logic [WORD_W-1:0] word,
    output logic              is_sync,
    output logic              last
);

    localparam int SW_W = $clog2(SYNC_WORDS + 1);

    logic              busy_reg;
    logic [SW_W-1:0]   sync_left_reg;
    logic [WORD_W-1:0] word_reg;
    logic              fire;

    assign result_valid = busy_reg;
    assign is_sync      = (sync_left_reg != '0);
    assign word         = is_sync ? SYNC_PATTERN : word_reg;
    assign last         = !is_sync;
    assign fire         = busy_reg && !result_stall;
    assign desc_ready   = !busy_reg || (fire && last);

    // control: busy flag and sync countdown
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            sync_left_reg <= '0;
        end
        else if (desc.valid)
        begin
            busy_reg      <= 1'b1;
            sync_left_reg <= desc.has_sync ? SW_W'(SYNC_WORDS) : '0;
        end
        else if (fire)
        begin
            if (is_sync)
                sync_left_reg <= sync_left_reg - 1'b1;
            else
                busy_reg <= 1'b0;
        end
    end

    // data word payload
    always_ff @(posedge clk)
    begin
        if (desc.valid)
            word_reg <= desc.word;
    end

    // the last sync word is always followed by the data word
    a_after_sync: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && sync_left_reg == SW_W'(1)) |=> (result_valid && !is_sync))
        else $error("data word missing after sync burst");

    // sync countdown never runs while idle
    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> (sync_left_reg == '0))
        else $error("sync count left while idle");

endmodule

@@ hw/rtl/timer_capture_entropy_extractor.sv @@
// Top level of the timer capture entropy extractor: APB register and wiring.
// Depends on tce_pkg, tce_core and tce_emit.
//
//  channel   signals                                   direction
//  capture   capture_valid/capture_stall, capture_value  in
//  result    result_valid/result_stall, word,          out
//            is_sync, last
//  config    psel, penable, pwrite, paddr, pwdata,     APB slave
//            prdata, pready
//
// Captures accepted one per cycle unless stalled, held in the input register.
// A capture with no result never waits. One with results waits until the
// result register is free; a delta word with sync holds the result side for the
// sync burst and data word, so the sync burst sets the sustained rate there.
// Reset clears all control state; the first delta word is preceded by sync.
// result_stall holds the current result and, once the input register holds
// a capture with a result, raises capture_stall in the same cycle.
module timer_capture_entropy_extractor
    import tce_pkg::*;
#(
    parameter int SYNC_PERIOD_WORDS = DEF_SYNC_PERIOD_WORDS,
    parameter int SYNC_WORDS        = DEF_SYNC_WORDS
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              capture_valid,
    output logic              capture_stall,
    input  logic [CAP_W-1:0]  capture_value,
    output logic              result_valid,
    input  logic              result_stall,
    output logic [WORD_W-1:0] word,
    output logic              is_sync,
    output logic              last,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    logic      mode_reg;
    logic      wr_en;
    logic      mode_wr;
    logic      desc_ready;
    tce_desc_t desc;

    // register access
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign mode_wr = wr_en && (paddr[2] == REG_MODE);
    assign prdata  = (paddr[2] == REG_MODE) ? {{(DATA_W-1){1'b0}}, mode_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= MODE_VN;
        else if (mode_wr)
            mode_reg <= pwdata[0];
    end

    tce_core #(
        .SYNC_PERIOD_WORDS (SYNC_PERIOD_WORDS)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .capture_valid (capture_valid),
        .capture_stall (capture_stall),
        .capture_value (capture_value),
        .mode          (mode_reg),
        .phase_clear   (mode_wr),
        .desc_ready    (desc_ready),
        .desc          (desc)
    );

    tce_emit #(
        .SYNC_WORDS (SYNC_WORDS)
    ) u_emit (
        .clk          (clk),
        .rst_n        (rst_n),
        .desc         (desc),
        .desc_ready   (desc_ready),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .word         (word),
        .is_sync      (is_sync),
        .last         (last)
    );

endmodule
